// ===== sv/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the farthest segment pair search.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_BITS   = 12;
    localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_BITS     = 4 * COORD_BITS;
    // squared distance shifted by 16 before the root
    localparam int RAD_BITS     = 2 * COORD_BITS + 1 + 16;
    localparam int ROOT_BITS    = (RAD_BITS + 1) / 2;
    localparam int SCORE_BITS   = ROOT_BITS + 1;
    localparam int STEP_BITS    = $clog2(ROOT_BITS + 1);

    typedef struct packed {
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [11:0] end_x;
        logic [11:0] end_y;
        logic        is_last;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [11:0] first_start_x;
        logic [11:0] first_start_y;
        logic [11:0] first_end_x;
        logic [11:0] first_end_y;
        logic [11:0] second_start_x;
        logic [11:0] second_start_y;
        logic [11:0] second_end_x;
        logic [11:0] second_end_y;
    } out_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
    } seg_t;

endpackage

// ===== sv/fsp_isqrt.sv =====
// ----------------------------------------------------------------------------
// fsp_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fsp_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [fsp_pkg::RAD_BITS-1:0]   radicand,
    output logic                           done,
    output logic [fsp_pkg::ROOT_BITS-1:0]  root
);

    localparam int RB = fsp_pkg::ROOT_BITS;

    logic [RB+1:0]         acc_reg, acc_next;
    logic [RB-1:0]         q_reg, q_next;
    logic [2*RB-1:0]       src_reg, src_next;
    logic [fsp_pkg::STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RB+1:0]         shifted, trial;

    always_comb begin
        shifted   = {acc_reg[RB-1:0], src_reg[2*RB-1 -: 2]};
        trial     = shifted - {q_reg, 2'b01};
        acc_next  = acc_reg;
        q_next    = q_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            src_next  = (2*RB)'(radicand);
            acc_next  = '0;
            q_next    = '0;
            cnt_next  = fsp_pkg::STEP_BITS'(RB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            src_next = src_reg << 2;
            if (!trial[RB+1]) begin
                acc_next = trial;
                q_next   = {q_reg[RB-2:0], 1'b1};
            end else begin
                acc_next = shifted;
                q_next   = {q_reg[RB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fsp_pkg::STEP_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        q_reg   <= q_next;
        src_reg <= src_next;
    end

    assign done = done_reg;
    assign root = q_reg;

endmodule

// ===== sv/farthest_segment_pair.sv =====
// ----------------------------------------------------------------------------
// farthest_segment_pair
// Loads segments and finds the pair with the largest endpoint distance sum.
// ----------------------------------------------------------------------------
// Each accepted segment word is written to the store. A word with is_last
// starts a search over all n*(n-1)/2 pairs; every pair needs store reads,
// squaring, two square roots on one shared bit-serial root unit and a compare,
// and a final fetch reads the chosen pair. The input is not ready during the
// search or while the result waits to be taken.
// Segments past MAX_SEGMENTS are dropped; fewer than two, or all-zero scores,
// give found=0 with zero coordinates.
module farthest_segment_pair (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fsp_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fsp_pkg::out_word_t m_data
);

    localparam int IB = fsp_pkg::IDX_BITS;
    localparam int CB = fsp_pkg::COORD_BITS;

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b000000001,
        ST_RDA   = 9'b000000010,
        ST_RDB   = 9'b000000100,
        ST_SQ    = 9'b000001000,
        ST_ROOT0 = 9'b000010000,
        ST_ROOT1 = 9'b000100000,
        ST_NEXT  = 9'b001000000,
        ST_FETCH = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    fsp_pkg::seg_t store_mem [fsp_pkg::MAX_SEGMENTS];
    fsp_pkg::seg_t rd_data;
    logic [IB-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [fsp_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic [IB-1:0] i_reg, i_next, j_reg, j_next;
    logic [IB-1:0] bi_reg, bi_next, bj_reg, bj_next;
    logic [fsp_pkg::SCORE_BITS-1:0] best_reg, best_next, score_reg, score_next;
    logic found_reg, found_next;
    fsp_pkg::seg_t a_reg, a_next, b_reg, b_next;
    logic [fsp_pkg::RAD_BITS-1:0] rad0_reg, rad0_next, rad1_reg, rad1_next;
    logic sq_sel_reg, sq_sel_next;
    logic root_start, root_done;
    logic [fsp_pkg::ROOT_BITS-1:0] root;
    logic [CB-1:0] dxa, dya;
    logic [2*CB-1:0] sqx, sqy;
    logic [2*CB:0] sumsq;
    logic wr_en;
    logic fetch_phase_reg, fetch_phase_next;
    fsp_pkg::out_word_t out_reg, out_next;
    logic [fsp_pkg::SCORE_BITS-1:0] total;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[count_reg[IB-1:0]] <= '{sx: s_data.start_x, sy: s_data.start_y,
                                              ex: s_data.end_x, ey: s_data.end_y};
        end
        rd_data <= store_mem[rd_addr];
    end

    fsp_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand ((state_reg == ST_ROOT0) ? rad1_reg : rad0_reg),
        .done     (root_done),
        .root     (root)
    );

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;
    assign wr_en   = s_valid && s_ready &&
                     (count_reg < fsp_pkg::CNT_BITS'(fsp_pkg::MAX_SEGMENTS));

    always_comb begin
        // one shared squarer path: pick endpoint pair by sq_sel_reg
        if (!sq_sel_reg) begin
            dxa = (a_reg.sx > b_reg.sx) ? a_reg.sx - b_reg.sx : b_reg.sx - a_reg.sx;
            dya = (a_reg.sy > b_reg.sy) ? a_reg.sy - b_reg.sy : b_reg.sy - a_reg.sy;
        end else begin
            dxa = (a_reg.ex > b_reg.ex) ? a_reg.ex - b_reg.ex : b_reg.ex - a_reg.ex;
            dya = (a_reg.ey > b_reg.ey) ? a_reg.ey - b_reg.ey : b_reg.ey - a_reg.ey;
        end
        sqx   = (2*CB)'(dxa) * (2*CB)'(dxa);
        sqy   = (2*CB)'(dya) * (2*CB)'(dya);
        sumsq = {1'b0, sqx} + {1'b0, sqy};
        total = score_reg + fsp_pkg::SCORE_BITS'(root);
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        bi_next          = bi_reg;
        bj_next          = bj_reg;
        best_next        = best_reg;
        score_next       = score_reg;
        found_next       = found_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        rad0_next        = rad0_reg;
        rad1_next        = rad1_reg;
        sq_sel_next      = sq_sel_reg;
        fetch_phase_next = fetch_phase_reg;
        out_next         = out_reg;
        root_start       = 1'b0;
        rd_addr          = i_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (wr_en) count_next = count_reg + 1'b1;
                    if (s_data.is_last) begin
                        i_next     = '0;
                        j_next     = IB'(1);
                        best_next  = '0;
                        found_next = 1'b0;
                        sq_sel_next = 1'b0;
                        if ((wr_en ? count_reg + 1'b1 : count_reg) < 2) begin
                            state_next = ST_FETCH;
                        end else begin
                            state_next = ST_RDA;
                        end
                        rd_addr = '0;
                    end
                end
            end
            ST_RDA: begin
                rd_addr    = j_reg;
                a_next     = rd_data;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                b_next      = rd_data;
                sq_sel_next = 1'b0;
                state_next  = ST_SQ;
            end
            ST_SQ: begin
                if (!sq_sel_reg) begin
                    rad0_next   = {sumsq, 16'b0};
                    sq_sel_next = 1'b1;
                end else begin
                    rad1_next   = {sumsq, 16'b0};
                    sq_sel_next = 1'b0;
                    root_start  = 1'b1;
                    state_next  = ST_ROOT0;
                end
            end
            ST_ROOT0: begin
                if (root_done) begin
                    score_next  = fsp_pkg::SCORE_BITS'(root);
                    sq_sel_next = 1'b1;
                    root_start  = 1'b1;
                    state_next  = ST_ROOT1;
                end
            end
            ST_ROOT1: begin
                if (root_done) begin
                    score_next  = total;
                    sq_sel_next = 1'b0;
                    state_next  = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (score_reg > best_reg) begin
                    best_next  = score_reg;
                    bi_next    = i_reg;
                    bj_next    = j_reg;
                    found_next = 1'b1;
                end
                if ({1'b0, j_reg} + 1'b1 < count_reg) begin
                    j_next     = j_reg + 1'b1;
                    rd_addr    = i_reg;
                    state_next = ST_RDA;
                end else if ({1'b0, i_reg} + 2 < count_reg) begin
                    i_next     = i_reg + 1'b1;
                    j_next     = i_reg + 2'd2;
                    rd_addr    = i_reg + 1'b1;
                    state_next = ST_RDA;
                end else begin
                    fetch_phase_next = 1'b0;
                    rd_addr          = (score_reg > best_reg) ? i_reg : bi_reg;
                    state_next       = ST_FETCH;
                end
            end
            ST_FETCH: begin
                rd_addr = bj_reg;
                if (!fetch_phase_reg) begin
                    a_next           = rd_data;
                    fetch_phase_next = 1'b1;
                end else begin
                    out_next.found = found_reg;
                    if (found_reg) begin
                        out_next.first_start_x  = a_reg.sx;
                        out_next.first_start_y  = a_reg.sy;
                        out_next.first_end_x    = a_reg.ex;
                        out_next.first_end_y    = a_reg.ey;
                        out_next.second_start_x = rd_data.sx;
                        out_next.second_start_y = rd_data.sy;
                        out_next.second_end_x   = rd_data.ex;
                        out_next.second_end_y   = rd_data.ey;
                    end else begin
                        out_next = '0;
                    end
                    fetch_phase_next = 1'b0;
                    count_next       = '0;
                    best_next        = '0;
                    state_next       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            count_reg       <= '0;
            best_reg        <= '0;
            bi_reg          <= '0;
            bj_reg          <= '0;
            found_reg       <= 1'b0;
            sq_sel_reg      <= 1'b0;
            fetch_phase_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            best_reg        <= best_next;
            bi_reg          <= bi_next;
            bj_reg          <= bj_next;
            found_reg       <= found_next;
            sq_sel_reg      <= sq_sel_next;
            fetch_phase_reg <= fetch_phase_next;
        end
        i_reg     <= i_next;
        j_reg     <= j_next;
        score_reg <= score_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        rad0_reg  <= rad0_next;
        rad1_reg  <= rad1_next;
        out_reg   <= out_next;
    end

endmodule

// ===== test/farthest_segment_pair_test.sv =====
// ----------------------------------------------------------------------------
// farthest_segment_pair_test
// Streams sets of segment words into the block and checks every pair result
// against a local search model. It covers directed extremes, ties, too few
// segments and store overflow, followed by random sets with random idling
// on both sides.
// ----------------------------------------------------------------------------
module farthest_segment_pair_test;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int RANDOM_WORDS   = 1400;

    typedef struct {
        fsp_pkg::in_word_t  word;
        bit                 typed;
        fsp_pkg::out_word_t result;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    fsp_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    fsp_pkg::out_word_t m_data;

    fsp_pkg::seg_t      loaded_segs[fsp_pkg::MAX_SEGMENTS];
    int                 loaded_count;
    fsp_pkg::out_word_t pending_pairs[$];
    int                 fail_count = 0;
    int                 idle_cycles = 0;

    farthest_segment_pair dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned endpoint_dist(int x1, int y1, int x2, int y2);
        longint unsigned dx;
        longint unsigned dy;
        dx = (x1 > x2) ? x1 - x2 : x2 - x1;
        dy = (y1 > y2) ? y1 - y2 : y2 - y1;
        return int_root((dx * dx + dy * dy) << 16);
    endfunction

    // store the word; on the last one search all pairs and queue the result
    function automatic void load_and_search(fsp_pkg::in_word_t w);
        longint unsigned    top_score;
        longint unsigned    score;
        int                 fi;
        int                 si;
        bit                 hit;
        fsp_pkg::out_word_t r;
        if (loaded_count < fsp_pkg::MAX_SEGMENTS) begin
            loaded_segs[loaded_count] = '{w.start_x, w.start_y, w.end_x, w.end_y};
            loaded_count++;
        end
        if (!w.is_last) return;
        top_score = 0;
        hit       = 1'b0;
        fi        = 0;
        si        = 0;
        for (int i = 0; i < loaded_count; i++) begin
            for (int j = i + 1; j < loaded_count; j++) begin
                score = endpoint_dist(loaded_segs[i].sx, loaded_segs[i].sy,
                                      loaded_segs[j].sx, loaded_segs[j].sy) +
                        endpoint_dist(loaded_segs[i].ex, loaded_segs[i].ey,
                                      loaded_segs[j].ex, loaded_segs[j].ey);
                if (score > top_score) begin
                    top_score = score;
                    fi        = i;
                    si        = j;
                    hit       = 1'b1;
                end
            end
        end
        r = '0;
        if (hit) begin
            r = '{1'b1, loaded_segs[fi].sx, loaded_segs[fi].sy, loaded_segs[fi].ex,
                  loaded_segs[fi].ey, loaded_segs[si].sx, loaded_segs[si].sy,
                  loaded_segs[si].ex, loaded_segs[si].ey};
        end
        pending_pairs.insert(pending_pairs.size(), r);
        loaded_count = 0;
    endfunction

    task automatic send_word(fsp_pkg::in_word_t w);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        load_and_search(w);
    endtask

    task automatic send_gap();
        int n;
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) n = 0;
        else if (pick < 93) n = $urandom_range(3, 1);
        else n = $urandom_range(40, 10);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    function automatic logic [11:0] rand_coord(int style);
        case (style)
            0: return 12'($urandom);
            1: return $urandom_range(1) ? 12'hFFF : 12'h000;
            2: return 12'($urandom_range(3));
            default: return 12'($urandom_range(4095, 4090));
        endcase
    endfunction

    function automatic fsp_pkg::in_word_t rand_word(bit last, int style);
        fsp_pkg::in_word_t w;
        w.start_x = rand_coord(style);
        w.start_y = rand_coord(style);
        w.end_x   = rand_coord(style);
        w.end_y   = rand_coord(style);
        w.is_last = last;
        return w;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        fsp_pkg::out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                $error("unexpected result word: found %0d", m_data.found);
                fail_count++;
            end else begin
                e = pending_pairs.pop_front();
                check_field("found", e.found, m_data.found);
                check_field("first_start_x", e.first_start_x, m_data.first_start_x);
                check_field("first_start_y", e.first_start_y, m_data.first_start_y);
                check_field("first_end_x", e.first_end_x, m_data.first_end_x);
                check_field("first_end_y", e.first_end_y, m_data.first_end_y);
                check_field("second_start_x", e.second_start_x, m_data.second_start_x);
                check_field("second_start_y", e.second_start_y, m_data.second_start_y);
                check_field("second_end_x", e.second_end_x, m_data.second_end_x);
                check_field("second_end_y", e.second_end_y, m_data.second_end_y);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int hold;
        m_ready = 1'b0;
        forever begin
            if ($urandom_range(99) < 75) begin
                hold = $urandom_range(20, 1);
                @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                hold = ($urandom_range(9) == 0) ? $urandom_range(60, 30)
                                                : $urandom_range(4, 1);
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            repeat (hold - 1) @(negedge aclk);
        end
    end

    initial begin
        stim_row_t rows[$];
        int        sent;
        int        set_size;
        int        style;
        bit        quiet;

        s_valid      = 1'b0;
        s_data       = '0;
        aresetn      = 1'b0;
        loaded_count = 0;
        for (int i = 0; i < fsp_pkg::MAX_SEGMENTS; i++) loaded_segs[i] = '0;

        // single segment, identical pair, full-scale extremes
        rows.insert(rows.size(), '{'{12'd5, 12'd5, 12'd5, 12'd5, 1'b1}, 1'b1, '0});
        rows.insert(rows.size(), '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1}, 1'b1,
                                   '{1'b1, 12'd0, 12'd0, 12'd0, 12'd0,
                                     12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}});
        rows.insert(rows.size(), '{'{12'd7, 12'd8, 12'd9, 12'd10, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'd7, 12'd8, 12'd9, 12'd10, 1'b1}, 1'b1, '0});
        // equal scores: earliest pair wins
        rows.insert(rows.size(), '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'd3, 12'd4, 12'd3, 12'd4, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'd10, 12'd0, 12'd10, 12'd0, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'd0, 12'd10, 12'd0, 12'd10, 1'b1}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'hFFF, 12'd0, 12'd0, 12'hFFF, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'd0, 12'hFFF, 12'hFFF, 12'd0, 1'b0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b1}, 1'b0, '0});

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[k]) begin
            send_word(rows[k].word);
            if (rows[k].typed && rows[k].word.is_last) begin
                pending_pairs[pending_pairs.size() - 1] = rows[k].result;
            end
            send_gap();
        end

        // hold until idle, then overflow the store: exactly full, then past full
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(negedge aclk);
        for (int i = 0; i < fsp_pkg::MAX_SEGMENTS; i++)
            send_word(rand_word(i == fsp_pkg::MAX_SEGMENTS - 1, 0));
        for (int i = 0; i < fsp_pkg::MAX_SEGMENTS + 6; i++)
            send_word(rand_word(i == fsp_pkg::MAX_SEGMENTS + 5, i % 4));
        send_gap();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            set_size = ($urandom_range(19) == 0) ? $urandom_range(20, 9)
                                                 : $urandom_range(8, 1);
            style    = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
            quiet    = ($urandom_range(4) == 0);
            for (int i = 0; i < set_size; i++) begin
                send_word(rand_word(i == set_size - 1,
                                    ($urandom_range(7) == 0) ? $urandom_range(3) : style));
                if (!quiet) send_gap();
            end
            sent += set_size;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/fsp_pkg.sv
sv/fsp_isqrt.sv
sv/farthest_segment_pair.sv
test/farthest_segment_pair_test.sv
